@@ design/i2a_pkg.sv @@
// Shared constants and the digit-to-character function of the integer to ASCII formatter.
`timescale 1ns / 1ps

package i2a_pkg;

  // Width of the value that is formatted; bits above it are ignored.
  localparam int VALUE_WIDTH = 64;

  // Decimal digits needed for VALUE_WIDTH bits: floor(VALUE_WIDTH * log10(2)) + 1.
  localparam int DEC_DIGITS = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int HEX_DIGITS = (VALUE_WIDTH + 3) / 4;
  localparam int DIG_N = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
  localparam int DIG_BITS = DIG_N * 4;
  localparam int NDIG_W = $clog2(DIG_N + 1);
  localparam int POS_W = 5;

  localparam logic [1:0] KIND_DEC = 2'd0;
  localparam logic [1:0] KIND_LOWER = 2'd1;
  localparam logic [1:0] KIND_UPPER = 2'd2;
  localparam logic [1:0] KIND_PTR = 2'd3;

  localparam logic [7:0] ASCII_ZERO = 8'd48;
  localparam logic [7:0] ASCII_MINUS = 8'd45;
  localparam logic [7:0] ASCII_X = 8'd120;
  localparam logic [7:0] LOWER_GAP = 8'd39;
  localparam logic [7:0] UPPER_GAP = 8'd7;

  // Maps one digit to its ASCII code; letters follow the case of the kind.
  function automatic logic [7:0] digit_char(input logic [3:0] d, input logic [1:0] kind);
    logic [7:0] ch;
    ch = {4'b0000, d} + ASCII_ZERO;
    if (d > 4'd9) begin
      ch = ch + ((kind == KIND_UPPER) ? UPPER_GAP : LOWER_GAP);
    end
    return ch;
  endfunction

endpackage

@@ design/i2a_conv.sv @@
// Bit-serial binary to digit converter: shift-and-add-3 for decimal, direct load for hex.
`timescale 1ns / 1ps

module i2a_conv (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        hex,
  input  logic [i2a_pkg::VALUE_WIDTH-1:0] mag,
  output logic                        done,
  output logic [i2a_pkg::DIG_BITS-1:0] digits
);

  localparam int CNT_W = (i2a_pkg::VALUE_WIDTH > 1) ? $clog2(i2a_pkg::VALUE_WIDTH) : 1;

  logic                             running;
  logic [CNT_W-1:0]                 cnt;
  logic [i2a_pkg::VALUE_WIDTH-1:0]  shreg;
  logic [i2a_pkg::DIG_BITS-1:0]     adj;
  logic [i2a_pkg::DIG_BITS-1:0]     digits_next;

  // Every decimal digit of 5 or more is corrected by 3 before the shift.
  always_comb begin
    for (int i = 0; i < i2a_pkg::DIG_N; i++) begin
      if (digits[i*4 +: 4] >= 4'd5) begin
        adj[i*4 +: 4] = digits[i*4 +: 4] + 4'd3;
      end else begin
        adj[i*4 +: 4] = digits[i*4 +: 4];
      end
    end
    digits_next = {adj[i2a_pkg::DIG_BITS-2:0], shreg[i2a_pkg::VALUE_WIDTH-1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        if (hex) begin
          digits <= {{(i2a_pkg::DIG_BITS - i2a_pkg::VALUE_WIDTH){1'b0}}, mag};
          done <= 1'b1;
        end else begin
          digits <= '0;
          shreg <= mag;
          cnt <= '0;
          running <= 1'b1;
        end
      end else if (running) begin
        digits <= digits_next;
        shreg <= shreg << 1;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(i2a_pkg::VALUE_WIDTH - 1)) begin
          running <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

@@ design/integer_to_ascii_formatter_core.sv @@
// Top level of the integer to ASCII formatter: request control, zero skipping and emission.
`timescale 1ns / 1ps

// A request is taken at a rising edge where start is high and busy is low. Its text leaves
// as one character per strobe cycle, most significant first, with its position in the run
// and last set on the final character. The receiver cannot hold characters off: each one
// is valid for exactly the single cycle in which strobe is high. A signed decimal value is
// first converted bit-serially over all its value bits, while the hex kinds load their
// digits directly; then leading zeros are dropped and the text is emitted, with a leading
// minus sign for a negative decimal value and the prefix "0x" for the pointer kind. busy
// falls in the cycle that carries the last character, so the next request may be taken at
// the edge that accepts it. The block holds one request at a time.

module integer_to_ascii_formatter_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      kind,
  input  logic [63:0]                     value,
  output logic                            strobe,
  output logic [7:0]                      character,
  output logic [i2a_pkg::POS_W-1:0]       position,
  output logic                            last
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CONV = 6'b000010,
    ST_SKIP = 6'b000100,
    ST_PRE0 = 6'b001000,
    ST_PRE1 = 6'b010000,
    ST_EMIT = 6'b100000
  } state_t;

  state_t                            state;
  logic [1:0]                        kind_q;
  logic                              neg;
  logic [i2a_pkg::DIG_BITS-1:0]      dig;
  logic [i2a_pkg::NDIG_W-1:0]        ndig;
  logic [i2a_pkg::POS_W-1:0]         pos;

  logic                              accept;
  logic [i2a_pkg::VALUE_WIDTH-1:0]   v_in;
  logic                              v_neg;
  logic [i2a_pkg::VALUE_WIDTH-1:0]   mag;
  logic                              conv_done;
  logic [i2a_pkg::DIG_BITS-1:0]      conv_digits;
  logic [3:0]                        top_digit;

  assign busy = (state != ST_IDLE);
  assign accept = start && !busy;

  // Only the low VALUE_WIDTH bits count. A negative decimal value is negated in unsigned
  // arithmetic, so the most negative value yields its full magnitude.
  assign v_in = value[i2a_pkg::VALUE_WIDTH-1:0];
  assign v_neg = (kind == i2a_pkg::KIND_DEC) && v_in[i2a_pkg::VALUE_WIDTH-1];
  assign mag = v_neg ? (~v_in + i2a_pkg::VALUE_WIDTH'(1)) : v_in;

  assign top_digit = dig[i2a_pkg::DIG_BITS-1 -: 4];

  i2a_conv u_conv (
    .clk    (clk),
    .rst    (rst),
    .start  (accept),
    .hex    (kind != i2a_pkg::KIND_DEC),
    .mag    (mag),
    .done   (conv_done),
    .digits (conv_digits)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            kind_q <= kind;
            neg <= v_neg;
            pos <= '0;
            state <= ST_CONV;
          end
        end
        ST_CONV: begin
          if (conv_done) begin
            dig <= conv_digits;
            ndig <= i2a_pkg::NDIG_W'(i2a_pkg::DIG_N);
            state <= ST_SKIP;
          end
        end
        ST_SKIP: begin
          // Leading zeros drop one digit per cycle; the last digit always stays.
          if (top_digit == 4'd0 && ndig > i2a_pkg::NDIG_W'(1)) begin
            dig <= dig << 4;
            ndig <= ndig - i2a_pkg::NDIG_W'(1);
          end else if (neg || kind_q == i2a_pkg::KIND_PTR) begin
            state <= ST_PRE0;
          end else begin
            state <= ST_EMIT;
          end
        end
        ST_PRE0: begin
          strobe <= 1'b1;
          character <= neg ? i2a_pkg::ASCII_MINUS : i2a_pkg::ASCII_ZERO;
          position <= pos;
          last <= 1'b0;
          pos <= pos + i2a_pkg::POS_W'(1);
          state <= (kind_q == i2a_pkg::KIND_PTR) ? ST_PRE1 : ST_EMIT;
        end
        ST_PRE1: begin
          strobe <= 1'b1;
          character <= i2a_pkg::ASCII_X;
          position <= pos;
          last <= 1'b0;
          pos <= pos + i2a_pkg::POS_W'(1);
          state <= ST_EMIT;
        end
        ST_EMIT: begin
          strobe <= 1'b1;
          character <= i2a_pkg::digit_char(top_digit, kind_q);
          position <= pos;
          last <= (ndig == i2a_pkg::NDIG_W'(1));
          pos <= pos + i2a_pkg::POS_W'(1);
          dig <= dig << 4;
          ndig <= ndig - i2a_pkg::NDIG_W'(1);
          if (ndig == i2a_pkg::NDIG_W'(1)) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
